// File: sv/ber_snmp_value_decoder_defines.svh
// Assertion macros for the BER value decoder.
`ifndef BER_SNMP_VALUE_DECODER_DEFINES_SVH
`define BER_SNMP_VALUE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define BSVD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bsvd: assertion failed");

`define BSVD_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("bsvd: forbidden condition seen");

`else

`define BSVD_ASSERT(lbl, clk, rstn, prop)

`define BSVD_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: sv/bsvd_pkg.sv
// Types, codes and constants shared by the BER value decoder.
package bsvd_pkg;

  localparam int unsigned MAX_LEN_OCTETS = 4;
  localparam int unsigned LEN_CNT_W      = $clog2(MAX_LEN_OCTETS + 1);

  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned PUSH_W    = $clog2(MAX_RES + 1);
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W     = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] TAG_OCTETS    = 8'h04;
  localparam logic [7:0] TAG_OID       = 8'h06;
  localparam logic [7:0] TAG_IPADDR    = 8'h40;
  localparam logic [7:0] TAG_COUNTER32 = 8'h41;
  localparam logic [7:0] TAG_GAUGE32   = 8'h42;
  localparam logic [7:0] TAG_TIMETICKS = 8'h43;
  localparam logic [7:0] TAG_OPAQUE    = 8'h44;
  localparam logic [7:0] TAG_COUNTER64 = 8'h46;
  localparam logic [7:0] TAG_UINT32    = 8'h47;

  localparam logic [63:0] INT_MAX_LEN = 64'd4;
  localparam logic [63:0] U32_MAX_LEN = 64'd5;
  localparam logic [63:0] C64_MAX_LEN = 64'd9;

  // floor(x / 5) equals (x * DIV5_MAGIC) >> 34 for every 32-bit x.
  localparam logic [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    MODE_INT   = 3'd0,
    MODE_U32   = 3'd1,
    MODE_C64   = 3'd2,
    MODE_OCTET = 3'd3,
    MODE_OID   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_SCALAR = 2'd0,
    KIND_OCTET  = 2'd1,
    KIND_OID    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_TAG   = 3'd2,
    ST_INDEF     = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_BAD_LEN   = 3'd5,
    ST_TRUNC     = 3'd6,
    ST_INC_OID   = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       sof;
    logic       eod;
    logic [2:0] mode;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  kind;
    logic [2:0]  status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [PUSH_W-1:0]         n;
    res_t [MAX_RES-1:0]        res;
  } push_t;

  function automatic res_t status_res(input logic [2:0] st);
    res_t r;
    r.value  = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t data_res(input logic [63:0] v, input logic [1:0] k,
                                    input logic lst);
    res_t r;
    r.value  = v;
    r.kind   = k;
    r.status = ST_OK;
    r.last   = lst;
    return r;
  endfunction

endpackage

// File: sv/bsvd_in_if.sv
// Input channel carrying one encoded byte per beat.
interface bsvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_element;
  logic       end_of_data;
  logic [2:0] mode;

  modport source (output valid, output in_byte, output start_of_element,
                  output end_of_data, output mode, input ready);
  modport sink (input valid, input in_byte, input start_of_element,
                input end_of_data, input mode, output ready);
endinterface

// File: sv/bsvd_out_if.sv
// Result channel carrying one decoded result per beat.
interface bsvd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output value, output kind, output status,
                  output last, input ready);
  modport sink (input valid, input value, input kind, input status,
                input last, output ready);
endinterface

// File: sv/bsvd_in_stage.sv
// Input register that holds one accepted byte until the decode step takes it.
module bsvd_in_stage import bsvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsvd_in_if.sink    in_i,
  input  logic       fire_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  assign in_i.ready = !valid_q || fire_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.in_byte <= in_i.in_byte;
      item_q.sof     <= in_i.start_of_element;
      item_q.eod     <= in_i.end_of_data;
      item_q.mode    <= in_i.mode;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: sv/bsvd_step.sv
// Element state and the per-byte decode that yields up to three results.
module bsvd_step import bsvd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t item_i,
  input  logic  room_i,
  output logic  fire_o,
  output push_t push_o
);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_LEN_FIRST = 2'd1;
  localparam logic [1:0] PH_LEN_LONG  = 2'd2;
  localparam logic [1:0] PH_VALUE     = 2'd3;

  logic [1:0]           phase_q, phase_d;
  logic [2:0]           mode_q, mode_d;
  logic [LEN_CNT_W-1:0] lcnt_q, lcnt_d, lcnt_dec;
  logic [31:0]          vleft_q, vleft_d, vleft_dec;
  logic                 first_q, first_d;
  logic [2:0]           total_q, total_d;
  logic [63:0]          acc_q, acc_d, acc_sh;
  logic                 fsub_q, fsub_d;
  logic                 neg_q, neg_d, neg_v;

  logic [7:0]           b;
  logic                 fire;
  logic                 done;
  logic                 do_fin;
  logic [63:0]          len_v;
  logic                 bad_len;
  logic [63:0]          sext;
  logic [31:0]          sub;
  logic [60:0]          prod;
  logic [26:0]          quot;
  logic [31:0]          rem;
  logic [PUSH_W-1:0]    n;
  res_t [MAX_RES-1:0]   res;

  function automatic logic tag_ok(input logic [2:0] m, input logic [7:0] t);
    logic ok;
    case (m)
      MODE_INT:   ok = (t == TAG_INTEGER);
      MODE_U32:   ok = (t == TAG_COUNTER32) || (t == TAG_GAUGE32) ||
                       (t == TAG_TIMETICKS) || (t == TAG_UINT32);
      MODE_C64:   ok = (t == TAG_COUNTER64);
      MODE_OCTET: ok = (t == TAG_OCTETS) || (t == TAG_IPADDR) || (t == TAG_OPAQUE);
      MODE_OID:   ok = (t == TAG_OID);
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign b    = item_i.in_byte;
  assign fire = in_valid_i && room_i;

  assign acc_sh    = {acc_q[55:0], b};
  assign lcnt_dec  = (lcnt_q != '0) ? lcnt_q - 1'b1 : lcnt_q;
  assign vleft_dec = vleft_q - 32'd1;
  assign done      = (vleft_dec == '0);
  assign sext      = ~64'd0 << {total_q, 3'b000};

  // Subidentifier accumulation and the split of the first one by forty.
  assign sub  = {acc_q[24:0], b[6:0]};
  assign prod = 61'(sub[31:3]) * 61'(DIV5_MAGIC);
  assign quot = prod[60:34];
  assign rem  = sub - ({quot, 5'b00000} + 32'({quot, 3'b000}));

  assign bad_len = ((mode_q == MODE_INT) && ((len_v == '0) || (len_v > INT_MAX_LEN))) ||
                   ((mode_q == MODE_U32) && ((len_v == '0) || (len_v > U32_MAX_LEN))) ||
                   ((mode_q == MODE_C64) && ((len_v == '0) || (len_v > C64_MAX_LEN)));

  always_comb begin
    phase_d = phase_q;
    mode_d  = mode_q;
    lcnt_d  = lcnt_q;
    vleft_d = vleft_q;
    first_d = first_q;
    total_d = total_q;
    acc_d   = acc_q;
    fsub_d  = fsub_q;
    neg_d   = neg_q;
    neg_v   = neg_q;
    do_fin  = 1'b0;
    len_v   = '0;
    n       = '0;
    res     = '0;

    if (item_i.sof) begin
      mode_d  = item_i.mode;
      lcnt_d  = '0;
      vleft_d = '0;
      total_d = '0;
      acc_d   = '0;
      fsub_d  = 1'b1;
      neg_d   = 1'b0;
      first_d = 1'b0;
      if (!tag_ok(item_i.mode, b)) begin
        res[0]  = status_res(ST_BAD_TAG);
        n       = PUSH_W'(1);
        phase_d = PH_IDLE;
      end else if (item_i.eod) begin
        res[0]  = status_res(ST_TRUNC);
        n       = PUSH_W'(1);
        phase_d = PH_IDLE;
      end else begin
        phase_d = PH_LEN_FIRST;
      end
    end else begin
      case (phase_q)
        PH_LEN_FIRST: begin
          if (!b[7]) begin
            do_fin = 1'b1;
            len_v  = 64'(b);
          end else if (b[6:0] == '0) begin
            res[0]  = status_res(ST_INDEF);
            n       = PUSH_W'(1);
            phase_d = PH_IDLE;
          end else if (b[6:0] > 7'(MAX_LEN_OCTETS)) begin
            res[0]  = status_res(ST_TOO_LARGE);
            n       = PUSH_W'(1);
            phase_d = PH_IDLE;
          end else if (item_i.eod) begin
            res[0]  = status_res(ST_TRUNC);
            n       = PUSH_W'(1);
            phase_d = PH_IDLE;
          end else begin
            lcnt_d  = b[LEN_CNT_W-1:0];
            acc_d   = '0;
            phase_d = PH_LEN_LONG;
          end
        end
        PH_LEN_LONG: begin
          acc_d  = acc_sh;
          lcnt_d = lcnt_dec;
          if (lcnt_dec == '0) begin
            do_fin = 1'b1;
            len_v  = acc_sh;
          end else if (item_i.eod) begin
            res[0]  = status_res(ST_TRUNC);
            n       = PUSH_W'(1);
            phase_d = PH_IDLE;
          end
        end
        PH_VALUE: begin
          if (vleft_q == '0) begin
            phase_d = PH_IDLE;
          end else begin
            vleft_d = vleft_dec;
            first_d = 1'b0;
            case (mode_q)
              MODE_INT: begin
                neg_v = first_q ? b[7] : neg_q;
                neg_d = neg_v;
                acc_d = acc_sh;
                if (done) begin
                  res[0] = data_res(neg_v ? (acc_sh | sext) : acc_sh, KIND_SCALAR, 1'b1);
                  n      = PUSH_W'(1);
                end
              end
              MODE_U32: begin
                acc_d = {32'd0, acc_sh[31:0]};
                if (done) begin
                  res[0] = data_res({32'd0, acc_sh[31:0]}, KIND_SCALAR, 1'b1);
                  n      = PUSH_W'(1);
                end
              end
              MODE_C64: begin
                acc_d = acc_sh;
                if (done) begin
                  res[0] = data_res(acc_sh, KIND_SCALAR, 1'b1);
                  n      = PUSH_W'(1);
                end
              end
              MODE_OCTET: begin
                res[0] = data_res(64'(b), KIND_OCTET, done);
                n      = PUSH_W'(1);
              end
              default: begin
                if (!b[7]) begin
                  acc_d = '0;
                  if (fsub_q) begin
                    res[0] = data_res(64'(quot), KIND_OID, 1'b0);
                    res[1] = data_res(64'(rem[5:0]), KIND_OID, done);
                    n      = PUSH_W'(2);
                    fsub_d = 1'b0;
                  end else begin
                    res[0] = data_res(64'(sub), KIND_OID, done);
                    n      = PUSH_W'(1);
                  end
                end else begin
                  acc_d = 64'(sub);
                  if (done) begin
                    res[0] = status_res(ST_INC_OID);
                    n      = PUSH_W'(1);
                  end
                end
              end
            endcase
            if (done) begin
              phase_d = PH_IDLE;
            end else if (item_i.eod) begin
              res[n]  = status_res(ST_TRUNC);
              n       = n + 1'b1;
              phase_d = PH_IDLE;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      if (do_fin) begin
        if (len_v[63:32] != '0) begin
          res[0]  = status_res(ST_TOO_LARGE);
          n       = PUSH_W'(1);
          phase_d = PH_IDLE;
        end else if (bad_len) begin
          res[0]  = status_res(ST_BAD_LEN);
          n       = PUSH_W'(1);
          phase_d = PH_IDLE;
        end else if (len_v == '0) begin
          res[0]  = status_res(ST_EMPTY);
          n       = PUSH_W'(1);
          phase_d = PH_IDLE;
        end else if (item_i.eod) begin
          res[0]  = status_res(ST_TRUNC);
          n       = PUSH_W'(1);
          phase_d = PH_IDLE;
        end else begin
          vleft_d = len_v[31:0];
          total_d = len_v[2:0];
          first_d = 1'b1;
          acc_d   = '0;
          neg_d   = 1'b0;
          fsub_d  = 1'b1;
          phase_d = PH_VALUE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mode_q  <= '0;
      lcnt_q  <= '0;
      vleft_q <= '0;
      first_q <= 1'b0;
      total_q <= '0;
      acc_q   <= '0;
      fsub_q  <= 1'b1;
      neg_q   <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      lcnt_q  <= lcnt_d;
      vleft_q <= vleft_d;
      first_q <= first_d;
      total_q <= total_d;
      acc_q   <= acc_d;
      fsub_q  <= fsub_d;
      neg_q   <= neg_d;
    end
  end

  assign fire_o   = fire;
  assign push_o.n = fire ? n : '0;
  assign push_o.res = res;

endmodule

// File: sv/bsvd_res_fifo.sv
// Result queue that takes up to three results at once and hands out one per beat.
module bsvd_res_fifo import bsvd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic             room_o,
  output logic [CNT_W-1:0] level_o,
  bsvd_out_if.source       out_o
);

  res_t             mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  res_t             head;

  assign pop      = out_o.valid && out_o.ready;
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.n);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign cnt_d    = CNT_W'(cnt_q + CNT_W'(push_i.n) - CNT_W'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (PUSH_W'(i) < push_i.n) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= push_i.res[i];
      end
    end
  end

  assign head         = mem_q[rd_ptr_q];
  assign out_o.valid  = (cnt_q != '0);
  assign out_o.value  = head.value;
  assign out_o.kind   = head.kind;
  assign out_o.status = head.status;
  assign out_o.last   = head.last;

  assign room_o  = (cnt_q <= CNT_W'(RES_DEPTH - MAX_RES));
  assign level_o = cnt_q;

endmodule

// File: sv/ber_snmp_value_decoder.sv
// BER value decoder top level: input register, decode step and result queue.
// An accepted byte waits in the input register; its results are offered from the queue.
// Throughput: one byte per cycle while each byte yields at most one result and the sink
// takes each result; else the next byte waits until the queue holds at most one result.
// Reset clears all element state, the held beat's valid flag and the queue at once.
module ber_snmp_value_decoder import bsvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsvd_in_if.sink    in_i,
  bsvd_out_if.source out_o
);

  `include "ber_snmp_value_decoder_defines.svh"

  logic             in_valid;
  item_t            item;
  logic             fire;
  logic             room;
  push_t            push;
  logic [CNT_W-1:0] level;
  logic             pop;

  bsvd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .fire_i  (fire),
    .valid_o (in_valid),
    .item_o  (item)
  );

  bsvd_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .item_i     (item),
    .room_i     (room),
    .fire_o     (fire),
    .push_o     (push)
  );

  bsvd_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .level_o (level),
    .out_o   (out_o)
  );

  assign pop = out_o.valid && out_o.ready;

  `BSVD_NEVER(a_queue_overflow, clk_i, rst_ni, level > CNT_W'(RES_DEPTH))
  `BSVD_NEVER(a_fire_needs_room, clk_i, rst_ni, fire && (level > CNT_W'(RES_DEPTH - MAX_RES)))
  `BSVD_ASSERT(a_held_beat_kept, clk_i, rst_ni, in_valid && !fire |=> in_valid)
  `BSVD_ASSERT(a_level_tracks, clk_i, rst_ni, 1'b1 |=> level == CNT_W'($past(level) + CNT_W'($past(push.n)) - CNT_W'($past(pop))))

endmodule

// File: bench/tb_ber_snmp_value_decoder.sv
// Self-checking bench for the BER value decoder: directed byte table, then random elements.
module tb_ber_snmp_value_decoder import bsvd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned BYTES_PER_PHASE = 76;
  localparam int unsigned OID_ARC_SPLIT   = 40;
  localparam logic [63:0] LEN_LIMIT       = 64'hFFFF_FFFF;
  localparam logic [7:0]  LONG_FORM       = 8'h80;
  localparam logic [2:0]  MODE_UNDEF_HI   = 3'd7;

  localparam logic [7:0] U32_TAGS [4] = '{TAG_COUNTER32, TAG_GAUGE32, TAG_TIMETICKS, TAG_UINT32};
  localparam logic [7:0] OCTET_TAGS [3] = '{TAG_OCTETS, TAG_IPADDR, TAG_OPAQUE};

  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_LEN_FIRST,
    DEC_LEN_LONG,
    DEC_VALUE
  } dec_phase_e;

  typedef struct {
    bit   typed;
    bit   yields;
    res_t res;
  } beat_note_t;

  typedef struct {
    item_t      it;
    beat_note_t note;
  } row_t;

  logic clk_i;
  logic rst_ni;

  bsvd_in_if  in_if ();
  bsvd_out_if out_if ();

  ber_snmp_value_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dec_phase_e  dec_phase = DEC_IDLE;
  logic [2:0]  dec_mode = '0;
  logic [2:0]  len_left = '0;
  logic [31:0] bytes_left = '0;
  logic [31:0] bytes_total = '0;
  logic [63:0] acc = '0;
  bit          split_pending = 1'b1;
  bit          negative = 1'b0;

  res_t        byte_results[$];
  res_t        expected_results[$];
  beat_note_t  beat_notes[$];

  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 64;
  bit          hold_req = 1'b0;
  int unsigned failures = 0;
  int unsigned quiet_cycles = 0;

  function automatic res_t status_only(input status_e st);
    res_t r;
    r.value  = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t make_result(input logic [63:0] v, input kind_e k, input bit lst);
    res_t r;
    r.value  = v;
    r.kind   = k;
    r.status = ST_OK;
    r.last   = lst;
    return r;
  endfunction

  function automatic row_t row(input logic [7:0] b, input bit sof, input bit eod,
                               input logic [2:0] md, input bit typed = 1'b0,
                               input bit yields = 1'b0, input res_t res = '0);
    row_t r;
    r.it.in_byte   = b;
    r.it.sof       = sof;
    r.it.eod       = eod;
    r.it.mode      = md;
    r.note.typed   = typed;
    r.note.yields  = yields;
    r.note.res     = res;
    return r;
  endfunction

  function automatic void queue_result(input res_t r);
    byte_results = {byte_results, r};
  endfunction

  function automatic void end_element(input status_e st);
    queue_result(status_only(st));
    dec_phase = DEC_IDLE;
  endfunction

  function automatic void finish_length(input logic [63:0] len, input bit eod);
    if (len > LEN_LIMIT) begin
      end_element(ST_TOO_LARGE);
    end else if ((dec_mode == MODE_INT && (len == 0 || len > INT_MAX_LEN)) ||
                 (dec_mode == MODE_U32 && (len == 0 || len > U32_MAX_LEN)) ||
                 (dec_mode == MODE_C64 && (len == 0 || len > C64_MAX_LEN))) begin
      end_element(ST_BAD_LEN);
    end else if (len == 0) begin
      end_element(ST_EMPTY);
    end else if (eod) begin
      end_element(ST_TRUNC);
    end else begin
      bytes_left    = len[31:0];
      bytes_total   = len[31:0];
      acc           = '0;
      negative      = 1'b0;
      split_pending = 1'b1;
      dec_phase     = DEC_VALUE;
    end
  endfunction

  // Advances the decoder state by one byte and appends its results to byte_results.
  function automatic void decode_byte(input item_t it);
    logic [7:0]  b;
    logic [6:0]  cnt;
    logic [63:0] v;
    bit          tag_ok;
    bit          first;
    bit          done;
    bit          oid_broken;
    b = it.in_byte;
    oid_broken = 1'b0;
    if (it.sof) begin
      dec_mode      = it.mode;
      len_left      = '0;
      bytes_left    = '0;
      bytes_total   = '0;
      acc           = '0;
      split_pending = 1'b1;
      negative      = 1'b0;
      case (it.mode)
        MODE_INT:   tag_ok = (b == TAG_INTEGER);
        MODE_U32:   tag_ok = (b == TAG_COUNTER32) || (b == TAG_GAUGE32) ||
                             (b == TAG_TIMETICKS) || (b == TAG_UINT32);
        MODE_C64:   tag_ok = (b == TAG_COUNTER64);
        MODE_OCTET: tag_ok = (b == TAG_OCTETS) || (b == TAG_IPADDR) || (b == TAG_OPAQUE);
        MODE_OID:   tag_ok = (b == TAG_OID);
        default:    tag_ok = 1'b0;
      endcase
      if (!tag_ok) begin
        end_element(ST_BAD_TAG);
      end else if (it.eod) begin
        end_element(ST_TRUNC);
      end else begin
        dec_phase = DEC_LEN_FIRST;
      end
      return;
    end
    case (dec_phase)
      DEC_LEN_FIRST: begin
        cnt = b[6:0];
        if (!b[7]) begin
          finish_length(64'(b), it.eod);
        end else if (cnt == 0) begin
          end_element(ST_INDEF);
        end else if (cnt > MAX_LEN_OCTETS) begin
          end_element(ST_TOO_LARGE);
        end else if (it.eod) begin
          end_element(ST_TRUNC);
        end else begin
          len_left  = 3'(cnt);
          acc       = '0;
          dec_phase = DEC_LEN_LONG;
        end
      end
      DEC_LEN_LONG: begin
        acc = {acc[55:0], b};
        if (len_left != 0) len_left--;
        if (len_left == 0) begin
          finish_length(acc, it.eod);
        end else if (it.eod) begin
          end_element(ST_TRUNC);
        end
      end
      DEC_VALUE: begin
        if (bytes_left == 0) begin
          dec_phase = DEC_IDLE;
        end else begin
          first = (bytes_left == bytes_total);
          bytes_left--;
          done = (bytes_left == 0);
          case (dec_mode)
            MODE_INT: begin
              if (first) negative = b[7];
              acc = {acc[55:0], b};
              if (done) begin
                v = acc;
                if (negative && bytes_total < 8) v |= ~64'd0 << (8 * bytes_total);
                queue_result(make_result(v, KIND_SCALAR, 1'b1));
              end
            end
            MODE_U32: begin
              acc = {32'd0, acc[23:0], b};
              if (done) queue_result(make_result(acc, KIND_SCALAR, 1'b1));
            end
            MODE_C64: begin
              acc = {acc[55:0], b};
              if (done) queue_result(make_result(acc, KIND_SCALAR, 1'b1));
            end
            MODE_OCTET: begin
              queue_result(make_result(64'(b), KIND_OCTET, done));
            end
            default: begin
              acc = {32'd0, acc[24:0], b[6:0]};
              if (!b[7]) begin
                if (split_pending) begin
                  queue_result(make_result(acc / OID_ARC_SPLIT, KIND_OID, 1'b0));
                  queue_result(make_result(acc % OID_ARC_SPLIT, KIND_OID, done));
                  split_pending = 1'b0;
                end else begin
                  queue_result(make_result(acc, KIND_OID, done));
                end
                acc = '0;
              end else if (done) begin
                oid_broken = 1'b1;
              end
            end
          endcase
          if (oid_broken) begin
            end_element(ST_INC_OID);
          end else if (done) begin
            dec_phase = DEC_IDLE;
          end else if (it.eod) begin
            end_element(ST_TRUNC);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(input item_t it, input beat_note_t note);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.in_byte          <= it.in_byte;
    in_if.start_of_element <= it.sof;
    in_if.end_of_data      <= it.eod;
    in_if.mode             <= it.mode;
    beat_notes = {beat_notes, note};
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // Sends one element, mostly well formed, and returns the number of beats sent.
  task automatic send_element(output int unsigned counted);
    logic [2:0]  md;
    logic [7:0]  tag;
    logic [7:0]  b;
    logic [31:0] len;
    int unsigned n_oct;
    int unsigned n_val;
    int unsigned cut;
    int unsigned cont_pct;
    bit          good;
    bit          huge;
    bit          trunc;
    logic [7:0]  enc[$];
    item_t       it;
    beat_note_t  predicted;
    predicted.typed  = 1'b0;
    predicted.yields = 1'b0;
    predicted.res    = '0;
    md = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    good = 1'b1;
    huge = 1'b0;
    case (md)
      MODE_INT:   begin tag = TAG_INTEGER;                   len = $urandom_range(4, 1);  end
      MODE_U32:   begin tag = U32_TAGS[$urandom_range(3)];   len = $urandom_range(5, 1);  end
      MODE_C64:   begin tag = TAG_COUNTER64;                 len = $urandom_range(9, 1);  end
      MODE_OCTET: begin tag = OCTET_TAGS[$urandom_range(2)]; len = $urandom_range(12);    end
      MODE_OID:   begin tag = TAG_OID;                       len = $urandom_range(10);    end
      default:    begin tag = 8'($urandom_range(255));       len = $urandom_range(4); good = 1'b0; end
    endcase
    if ($urandom_range(9) == 0) begin
      tag  = 8'($urandom_range(255));
      good = 1'b0;
    end
    if ($urandom_range(11) == 0) len = $urandom_range(40);
    enc = {enc, tag};
    case ($urandom_range(19))
      0: begin
        enc  = {enc, LONG_FORM};
        good = 1'b0;
      end
      1: begin
        enc  = {enc, LONG_FORM | 8'($urandom_range(127, MAX_LEN_OCTETS + 1))};
        good = 1'b0;
      end
      2: begin
        len  = $urandom();
        huge = 1'b1;
        enc  = {enc, LONG_FORM | 8'd4};
        for (int i = 3; i >= 0; i--) enc = {enc, 8'(len >> (8 * i))};
      end
      3, 4, 5, 6, 7: begin
        n_oct = $urandom_range(MAX_LEN_OCTETS, 1);
        enc   = {enc, LONG_FORM | 8'(n_oct)};
        for (int i = int'(n_oct) - 1; i >= 0; i--) enc = {enc, 8'(len >> (8 * i))};
      end
      default: enc = {enc, 8'(len)};
    endcase
    if ((md == MODE_INT && (len == 0 || len > INT_MAX_LEN)) ||
        (md == MODE_U32 && (len == 0 || len > U32_MAX_LEN)) ||
        (md == MODE_C64 && (len == 0 || len > C64_MAX_LEN)) || len == 0)
      good = 1'b0;
    n_val = !good ? $urandom_range(2) : (huge ? $urandom_range(8) : len);
    cont_pct = ($urandom_range(3) == 0) ? 85 : 30;
    for (int unsigned i = 0; i < n_val; i++) begin
      b = 8'($urandom_range(255));
      if (md == MODE_OID) begin
        b[7] = ($urandom_range(99) < cont_pct);
        if (i == n_val - 1 && $urandom_range(9) != 0) b[7] = 1'b0;
      end
      enc = {enc, b};
    end
    cut = enc.size();
    trunc = 1'b0;
    case ($urandom_range(15))
      0: begin
        trunc = 1'b1;
        cut   = $urandom_range(enc.size() - 1) + 1;
      end
      1: cut = $urandom_range(enc.size() - 1, 1);
      default: ;
    endcase
    counted = cut;
    for (int unsigned i = 0; i < cut; i++) begin
      it.in_byte = enc[i];
      it.sof     = (i == 0);
      it.mode    = (i == 0) ? md : 3'($urandom_range(7));
      it.eod     = (trunc && i == cut - 1) ||
                   (i == enc.size() - 1 && $urandom_range(7) == 0);
      send_beat(it, predicted);
    end
    if ($urandom_range(14) == 0) begin
      it.in_byte = 8'($urandom_range(255));
      it.sof     = 1'b0;
      it.eod     = $urandom_range(1);
      it.mode    = 3'($urandom_range(7));
      send_beat(it, predicted);
      counted++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    item_t      it;
    beat_note_t note;
    res_t       got;
    res_t       want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        moved      = 1'b1;
        it.in_byte = in_if.in_byte;
        it.sof     = in_if.start_of_element;
        it.eod     = in_if.end_of_data;
        it.mode    = in_if.mode;
        note = beat_notes.pop_front();
        byte_results.delete();
        decode_byte(it);
        if (note.typed) begin
          byte_results.delete();
          if (note.yields) queue_result(note.res);
        end
        expected_results = {expected_results, byte_results};
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        moved      = 1'b1;
        got.value  = out_if.value;
        got.kind   = out_if.kind;
        got.status = out_if.status;
        got.last   = out_if.last;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: value %h kind %0d status %0d last %0d",
                 got.value, got.kind, got.status, got.last);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            failures++;
          end
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            failures++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t        dir_rows[$];
    int unsigned sent;
    int unsigned beats;
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.in_byte          = '0;
    in_if.start_of_element = 1'b0;
    in_if.end_of_data      = 1'b0;
    in_if.mode             = MODE_INT;

    // Stray byte while idle is ignored, end of data with it too.
    dir_rows = {dir_rows, row(8'hFF, 1'b0, 1'b1, MODE_INT, 1'b1)};
    dir_rows = {dir_rows, row(TAG_INTEGER, 1'b1, 1'b0, MODE_INT, 1'b1)};
    dir_rows = {dir_rows, row(8'h01, 1'b0, 1'b0, MODE_INT, 1'b1)};
    dir_rows = {dir_rows, row(8'h80, 1'b0, 1'b0, MODE_INT, 1'b1, 1'b1,
                              make_result(64'hFFFF_FFFF_FFFF_FF80, KIND_SCALAR, 1'b1))};
    dir_rows = {dir_rows, row(8'h05, 1'b1, 1'b0, MODE_UNDEF_HI, 1'b1, 1'b1,
                              status_only(ST_BAD_TAG))};
    dir_rows = {dir_rows, row(TAG_INTEGER, 1'b1, 1'b0, MODE_INT)};
    dir_rows = {dir_rows, row(LONG_FORM, 1'b0, 1'b0, MODE_INT, 1'b1, 1'b1,
                              status_only(ST_INDEF))};
    dir_rows = {dir_rows, row(TAG_COUNTER32, 1'b1, 1'b0, MODE_U32)};
    dir_rows = {dir_rows, row(8'h85, 1'b0, 1'b0, MODE_U32, 1'b1, 1'b1,
                              status_only(ST_TOO_LARGE))};
    dir_rows = {dir_rows, row(TAG_COUNTER64, 1'b1, 1'b0, MODE_C64)};
    dir_rows = {dir_rows, row(8'h0A, 1'b0, 1'b0, MODE_C64, 1'b1, 1'b1,
                              status_only(ST_BAD_LEN))};
    dir_rows = {dir_rows, row(TAG_OCTETS, 1'b1, 1'b0, MODE_OCTET)};
    dir_rows = {dir_rows, row(8'h00, 1'b0, 1'b0, MODE_OCTET, 1'b1, 1'b1,
                              status_only(ST_EMPTY))};
    dir_rows = {dir_rows, row(TAG_OID, 1'b1, 1'b0, MODE_OID)};
    dir_rows = {dir_rows, row(8'h81, 1'b0, 1'b0, MODE_OID)};
    dir_rows = {dir_rows, row(8'h03, 1'b0, 1'b0, MODE_OID)};
    dir_rows = {dir_rows, row(8'h2B, 1'b0, 1'b0, MODE_OID)};
    dir_rows = {dir_rows, row(8'hFF, 1'b0, 1'b0, MODE_OID)};
    dir_rows = {dir_rows, row(8'h8F, 1'b0, 1'b0, MODE_OID, 1'b1, 1'b1,
                              status_only(ST_INC_OID))};
    dir_rows = {dir_rows, row(TAG_UINT32, 1'b1, 1'b0, MODE_U32)};
    dir_rows = {dir_rows, row(8'h05, 1'b0, 1'b0, MODE_U32)};
    dir_rows = {dir_rows, row(8'hFF, 1'b0, 1'b0, MODE_U32)};
    dir_rows = {dir_rows, row(8'hFF, 1'b0, 1'b0, MODE_U32)};
    // A new tag abandons the unfinished unsigned32 element.
    dir_rows = {dir_rows, row(TAG_INTEGER, 1'b1, 1'b0, MODE_INT)};
    dir_rows = {dir_rows, row(8'h04, 1'b0, 1'b1, MODE_INT, 1'b1, 1'b1,
                              status_only(ST_TRUNC))};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i].it, dir_rows[i].note);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 23; rx_idle_pct = 64; end
        1: begin tx_idle_pct = 64; rx_idle_pct = 23; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        send_element(beats);
        sent += beats;
      end
    end
    in_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bsvd_pkg.sv
sv/bsvd_in_if.sv
sv/bsvd_out_if.sv
sv/bsvd_in_stage.sv
sv/bsvd_step.sv
sv/bsvd_res_fifo.sv
sv/ber_snmp_value_decoder.sv
bench/tb_ber_snmp_value_decoder.sv
